// File: design/t2u_pkg.sv
`default_nettype none

package t2u_pkg;

    // Encoding byte values at the head of a payload.
    localparam logic [7:0] ENC_LATIN1  = 8'h00;
    localparam logic [7:0] ENC_UTF16   = 8'h01;
    localparam logic [7:0] ENC_UTF16BE = 8'h02;
    localparam logic [7:0] ENC_UTF8    = 8'h03;

    // Byte-order mark halves.
    localparam logic [7:0] MARK_FE = 8'hFE;
    localparam logic [7:0] MARK_FF = 8'hFF;

    // UTF-8 length limits and lead/continuation prefixes.
    localparam logic [15:0] LIMIT_ONE = 16'h0080;
    localparam logic [15:0] LIMIT_TWO = 16'h0800;
    localparam logic [7:0]  LEAD_TWO   = 8'hC0;
    localparam logic [7:0]  LEAD_THREE = 8'hE0;
    localparam logic [7:0]  CONT_MARK  = 8'h80;
    localparam logic [7:0]  CONT_MASK  = 8'h3F;

    localparam int BURST_MAX = 3;

    // Index of a word within a burst.
    localparam logic [1:0] IDX_FIRST  = 2'd0;
    localparam logic [1:0] IDX_SECOND = 2'd1;
    localparam logic [1:0] IDX_THIRD  = 2'd2;

    // The output words caused by one input byte.
    typedef struct packed {
        logic [1:0]                      last_idx;
        logic                            has_bytes;
        logic                            string_end;
        logic [BURST_MAX-1:0][7:0]       bytes;
    } burst_t;

    // Handshake between the emitter and the stages in front of it.
    typedef struct packed {
        logic free;
    } emit_status_t;

endpackage

`default_nettype wire

// File: design/t2u_decode.sv
`default_nettype none

module t2u_decode (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire logic [7:0]      in_byte,
    input  wire logic            in_last,
    output t2u_pkg::burst_t      burst
);

    logic        expect_encoding_reg, expect_encoding_next;
    logic        byte_mode_reg, byte_mode_next;
    logic        big_endian_reg, big_endian_next;
    logic        check_mark_reg, check_mark_next;
    logic        stopped_reg, stopped_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        have_held_reg, have_held_next;

    logic        order_be;
    logic        drop_unit;
    logic [15:0] unit;

    always_comb
    begin
        expect_encoding_next = expect_encoding_reg;
        byte_mode_next       = byte_mode_reg;
        big_endian_next      = big_endian_reg;
        check_mark_next      = check_mark_reg;
        stopped_next         = stopped_reg;
        held_byte_next       = held_byte_reg;
        have_held_next       = have_held_reg;
        burst                = '0;
        order_be             = big_endian_reg;
        drop_unit            = 1'b0;
        unit                 = '0;

        if (expect_encoding_reg)
        begin
            byte_mode_next       = (in_byte == t2u_pkg::ENC_LATIN1) ||
                                   (in_byte == t2u_pkg::ENC_UTF8);
            big_endian_next      = (in_byte == t2u_pkg::ENC_UTF16BE);
            check_mark_next      = (in_byte == t2u_pkg::ENC_UTF16);
            stopped_next         = 1'b0;
            have_held_next       = 1'b0;
            held_byte_next       = '0;
            expect_encoding_next = 1'b0;
        end
        else if (stopped_reg)
        begin
            // Everything after a terminator is swallowed.
        end
        else if (byte_mode_reg)
        begin
            if (in_byte == 8'h00)
            begin
                stopped_next = 1'b1;
            end
            else
            begin
                burst.has_bytes = 1'b1;
                burst.bytes[0]  = in_byte;
            end
        end
        else if (!have_held_reg)
        begin
            held_byte_next = in_byte;
            have_held_next = 1'b1;
        end
        else
        begin
            have_held_next = 1'b0;
            held_byte_next = '0;
            if (check_mark_reg)
            begin
                check_mark_next = 1'b0;
                if (held_byte_reg == t2u_pkg::MARK_FE && in_byte == t2u_pkg::MARK_FF)
                begin
                    order_be  = 1'b1;
                    drop_unit = 1'b1;
                end
                else if (held_byte_reg == t2u_pkg::MARK_FF &&
                         in_byte == t2u_pkg::MARK_FE)
                begin
                    order_be  = 1'b0;
                    drop_unit = 1'b1;
                end
            end
            big_endian_next = order_be;
            unit = order_be ? {held_byte_reg, in_byte} : {in_byte, held_byte_reg};

            if (!drop_unit)
            begin
                if (unit == 16'h0000)
                begin
                    stopped_next = 1'b1;
                end
                else if (unit < t2u_pkg::LIMIT_ONE)
                begin
                    burst.has_bytes = 1'b1;
                    burst.bytes[0]  = unit[7:0];
                end
                else if (unit < t2u_pkg::LIMIT_TWO)
                begin
                    burst.has_bytes = 1'b1;
                    burst.last_idx  = t2u_pkg::IDX_SECOND;
                    burst.bytes[0]  = t2u_pkg::LEAD_TWO | {3'b000, unit[10:6]};
                    burst.bytes[1]  = t2u_pkg::CONT_MARK |
                                      ({2'b00, unit[5:0]} & t2u_pkg::CONT_MASK);
                end
                else
                begin
                    burst.has_bytes = 1'b1;
                    burst.last_idx  = t2u_pkg::IDX_THIRD;
                    burst.bytes[0]  = t2u_pkg::LEAD_THREE | {4'b0000, unit[15:12]};
                    burst.bytes[1]  = t2u_pkg::CONT_MARK |
                                      ({2'b00, unit[11:6]} & t2u_pkg::CONT_MASK);
                    burst.bytes[2]  = t2u_pkg::CONT_MARK |
                                      ({2'b00, unit[5:0]} & t2u_pkg::CONT_MASK);
                end
            end
        end

        burst.string_end = in_last;

        // The end of a payload puts every piece of state back to its reset value.
        if (in_last)
        begin
            expect_encoding_next = 1'b1;
            byte_mode_next       = 1'b0;
            big_endian_next      = 1'b0;
            check_mark_next      = 1'b0;
            stopped_next         = 1'b0;
            held_byte_next       = '0;
            have_held_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_encoding_reg <= 1'b1;
            byte_mode_reg       <= 1'b0;
            big_endian_reg      <= 1'b0;
            check_mark_reg      <= 1'b0;
            stopped_reg         <= 1'b0;
            held_byte_reg       <= '0;
            have_held_reg       <= 1'b0;
        end
        else if (load)
        begin
            expect_encoding_reg <= expect_encoding_next;
            byte_mode_reg       <= byte_mode_next;
            big_endian_reg      <= big_endian_next;
            check_mark_reg      <= check_mark_next;
            stopped_reg         <= stopped_next;
            held_byte_reg       <= held_byte_next;
            have_held_reg       <= have_held_next;
        end
    end

endmodule

`default_nettype wire

// File: design/t2u_emit.sv
`default_nettype none

module t2u_emit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire t2u_pkg::burst_t       burst_in,
    input  wire logic                  out_stall,
    output t2u_pkg::emit_status_t      status,
    output logic                       out_valid,
    output logic [7:0]                 out_byte,
    output logic                       out_byte_valid,
    output logic                       out_run_last,
    output logic                       out_string_end
);

    t2u_pkg::burst_t burst_reg;
    logic            valid_reg;
    logic [1:0]      idx_reg;
    logic            at_last;

    assign at_last        = (idx_reg == burst_reg.last_idx);
    assign status.free    = !valid_reg || (!out_stall && at_last);
    assign out_valid      = valid_reg;
    assign out_byte_valid = burst_reg.has_bytes;
    assign out_run_last   = at_last;
    assign out_string_end = burst_reg.string_end && at_last;

    always_comb
    begin
        case (idx_reg)
            t2u_pkg::IDX_FIRST:  out_byte = burst_reg.bytes[0];
            t2u_pkg::IDX_SECOND: out_byte = burst_reg.bytes[1];
            t2u_pkg::IDX_THIRD:  out_byte = burst_reg.bytes[2];
            default:             out_byte = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= t2u_pkg::IDX_FIRST;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= t2u_pkg::IDX_FIRST;
        end
        else if (valid_reg && !out_stall)
        begin
            if (at_last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= burst_in;
        end
    end

endmodule

`default_nettype wire

// File: design/tag_text_to_utf8.sv
// Channel  | Direction | Handshake                    | Word
// payload  | in        | payload_valid/payload_stall  | payload_byte, payload_last
// result   | out       | result_valid/result_stall    | utf8_byte, byte_valid,
//          |           |                              | run_last, string_end
//
// An accepted byte waits in the input register, is decoded into a burst of one to
// three result words, and goes into the emitter's burst register, from which they go out.
// The result port sends one word per cycle while result_stall is low, so a byte
// holds the port until the last word of its burst is taken.
// A new byte is taken while the last word of the previous burst goes out.
// Reset clears all control state and puts the decoder back to expect an encoding byte.
`default_nettype none

module tag_text_to_utf8 (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        payload_valid,
    output logic             payload_stall,
    input  wire logic [7:0]  payload_byte,
    input  wire logic        payload_last,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [7:0]       utf8_byte,
    output logic             byte_valid,
    output logic             run_last,
    output logic             string_end
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    logic                  accept;
    logic                  load;
    t2u_pkg::burst_t       burst;
    t2u_pkg::emit_status_t status;

    assign load          = in_valid_reg && status.free;
    assign payload_stall = in_valid_reg && !status.free;
    assign accept        = payload_valid && !payload_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (load)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= payload_byte;
            in_last_reg <= payload_last;
        end
    end

    t2u_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .burst   (burst)
    );

    t2u_emit u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .burst_in       (burst),
        .out_stall      (result_stall),
        .status         (status),
        .out_valid      (result_valid),
        .out_byte       (utf8_byte),
        .out_byte_valid (byte_valid),
        .out_run_last   (run_last),
        .out_string_end (string_end)
    );

endmodule

`default_nettype wire

// File: design/t2u_checker.sv
`default_nettype none

module t2u_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       payload_valid,
    input wire logic       payload_stall,
    input wire logic [7:0] payload_byte,
    input wire logic       payload_last,
    input wire logic       result_valid,
    input wire logic       result_stall,
    input wire logic [7:0] utf8_byte,
    input wire logic       byte_valid,
    input wire logic       run_last,
    input wire logic       string_end
);

    // A stalled result word holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(utf8_byte) && $stable(byte_valid) &&
            $stable(run_last) && $stable(string_end))
        else $error("result word changed while stalled");

    // The end of a payload always closes a burst.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && string_end |-> run_last)
        else $error("string_end without run_last");

    // A word that carries no text byte is alone in its burst and reads zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !byte_valid |-> run_last && utf8_byte == 8'h00)
        else $error("empty word inside a multi-word burst");

    // Words of one burst go out back to back and all carry text.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !run_last |=>
            result_valid && byte_valid && $past(byte_valid))
        else $error("burst broken or holds an empty word");

endmodule

bind tag_text_to_utf8 t2u_checker u_t2u_checker (.*);

`default_nettype wire

// File: bench/utf8_stream_check.sv
`timescale 1ns / 1ps

module utf8_stream_check (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       payload_valid,
    input  wire logic       payload_stall,
    input  wire logic [7:0] payload_byte,
    input  wire logic       payload_last,
    input  wire logic       result_valid,
    input  wire logic       result_stall,
    input  wire logic [7:0] utf8_byte,
    input  wire logic       byte_valid,
    input  wire logic       run_last,
    input  wire logic       string_end,
    output int              mismatch_count,
    output int              words_pending
);

    typedef struct {
        logic [7:0] text;
        logic       valid;
        logic       run_end;
        logic       str_end;
    } utf8_word_t;

    utf8_word_t utf8_words_q[$];
    int         fails = 0;
    int         backlog = 0;

    // Decoder state, mirrored from the block's behavior.
    logic       awaiting_enc;
    logic       pass_through;
    logic       unit_be;
    logic       mark_pending;
    logic       halted;
    logic [7:0] held;
    logic       held_ok;

    assign mismatch_count = fails;
    assign words_pending  = backlog;

    task automatic clear_decoder();
        awaiting_enc = 1'b1;
        pass_through = 1'b0;
        unit_be      = 1'b0;
        mark_pending = 1'b0;
        halted       = 1'b0;
        held         = 8'h00;
        held_ok      = 1'b0;
    endtask

    // Works out the words that one accepted payload byte causes.
    task automatic decode_payload_byte(input logic [7:0] b, input logic last);
        logic [7:0]  outb [3];
        int          n;
        logic        drop;
        logic [15:0] unit;
        utf8_word_t  w;
        n    = 0;
        drop = 1'b0;
        if (awaiting_enc)
        begin
            pass_through = (b == t2u_pkg::ENC_LATIN1) || (b == t2u_pkg::ENC_UTF8);
            unit_be      = (b == t2u_pkg::ENC_UTF16BE);
            mark_pending = (b == t2u_pkg::ENC_UTF16);
            halted       = 1'b0;
            held_ok      = 1'b0;
            held         = 8'h00;
            awaiting_enc = 1'b0;
        end
        else if (halted)
        begin
            n = 0;
        end
        else if (pass_through)
        begin
            if (b == 8'h00)
                halted = 1'b1;
            else
            begin
                outb[0] = b;
                n = 1;
            end
        end
        else if (!held_ok)
        begin
            held    = b;
            held_ok = 1'b1;
        end
        else
        begin
            if (mark_pending)
            begin
                mark_pending = 1'b0;
                if (held == t2u_pkg::MARK_FE && b == t2u_pkg::MARK_FF)
                begin
                    unit_be = 1'b1;
                    drop    = 1'b1;
                end
                else if (held == t2u_pkg::MARK_FF && b == t2u_pkg::MARK_FE)
                begin
                    unit_be = 1'b0;
                    drop    = 1'b1;
                end
            end
            unit    = unit_be ? {held, b} : {b, held};
            held    = 8'h00;
            held_ok = 1'b0;
            if (!drop)
            begin
                if (unit == 16'h0000)
                begin
                    halted = 1'b1;
                end
                else if (unit < t2u_pkg::LIMIT_ONE)
                begin
                    outb[0] = unit[7:0];
                    n = 1;
                end
                else if (unit < t2u_pkg::LIMIT_TWO)
                begin
                    outb[0] = t2u_pkg::LEAD_TWO | 8'(unit >> 6);
                    outb[1] = t2u_pkg::CONT_MARK | (unit[7:0] & t2u_pkg::CONT_MASK);
                    n = 2;
                end
                else
                begin
                    outb[0] = t2u_pkg::LEAD_THREE | 8'(unit >> 12);
                    outb[1] = t2u_pkg::CONT_MARK | (8'(unit >> 6) & t2u_pkg::CONT_MASK);
                    outb[2] = t2u_pkg::CONT_MARK | (unit[7:0] & t2u_pkg::CONT_MASK);
                    n = 3;
                end
            end
        end

        if (n == 0)
        begin
            w.text    = 8'h00;
            w.valid   = 1'b0;
            w.run_end = 1'b1;
            w.str_end = last;
            utf8_words_q.push_back(w);
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                w.text    = outb[i];
                w.valid   = 1'b1;
                w.run_end = (i == n - 1);
                w.str_end = last && (i == n - 1);
                utf8_words_q.push_back(w);
            end
        end
        if (last)
            clear_decoder();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        utf8_word_t want;
        if (!rst_n)
        begin
            clear_decoder();
            utf8_words_q.delete();
        end
        else
        begin
            if (payload_valid && !payload_stall)
                decode_payload_byte(payload_byte, payload_last);
            if (result_valid && !result_stall)
            begin
                if (utf8_words_q.size() == 0)
                begin
                    $error("result word %h/%b/%b/%b arrived with nothing expected",
                           utf8_byte, byte_valid, run_last, string_end);
                    fails++;
                end
                else
                begin
                    want = utf8_words_q.pop_front();
                    if (utf8_byte !== want.text)
                    begin
                        $error("utf8_byte: expected %h, got %h", want.text, utf8_byte);
                        fails++;
                    end
                    if (byte_valid !== want.valid)
                    begin
                        $error("byte_valid: expected %b, got %b", want.valid, byte_valid);
                        fails++;
                    end
                    if (run_last !== want.run_end)
                    begin
                        $error("run_last: expected %b, got %b", want.run_end, run_last);
                        fails++;
                    end
                    if (string_end !== want.str_end)
                    begin
                        $error("string_end: expected %b, got %b", want.str_end, string_end);
                        fails++;
                    end
                end
            end
        end
        backlog = utf8_words_q.size();
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT = 4000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       payload_valid = 1'b0;
    logic       payload_stall;
    logic [7:0] payload_byte = 8'h00;
    logic       payload_last = 1'b0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic [7:0] utf8_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;

    int         mismatch_count;
    int         words_pending;
    int         idle_cycles = 0;
    int         bytes_sent = 0;
    logic       quiet_run = 1'b0;
    logic       hold_off_req = 1'b0;
    logic [7:0] text_q[$];

    always #2 clk = ~clk;

    tag_text_to_utf8 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .payload_valid (payload_valid),
        .payload_stall (payload_stall),
        .payload_byte  (payload_byte),
        .payload_last  (payload_last),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .utf8_byte     (utf8_byte),
        .byte_valid    (byte_valid),
        .run_last      (run_last),
        .string_end    (string_end)
    );

    utf8_stream_check checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .payload_valid  (payload_valid),
        .payload_stall  (payload_stall),
        .payload_byte   (payload_byte),
        .payload_last   (payload_last),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .utf8_byte      (utf8_byte),
        .byte_valid     (byte_valid),
        .run_last       (run_last),
        .string_end     (string_end),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    // Offers one byte and returns once it has been taken.
    task automatic offer_byte(input logic [7:0] b, input logic last);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (quiet_run || r < 60)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0)
        begin
            payload_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        payload_valid <= 1'b1;
        payload_byte  <= b;
        payload_last  <= last;
        @(posedge clk);
        while (payload_stall) @(posedge clk);
    endtask

    task automatic send_payload();
        for (int i = 0; i < text_q.size(); i++)
            offer_byte(text_q[i], i == text_q.size() - 1);
        bytes_sent += text_q.size();
    endtask

    function automatic logic [15:0] pick_unit();
        int r;
        r = $urandom_range(0, 39);
        if (r == 0)
            return 16'h0000;
        else if (r < 14)
            return 16'($urandom_range(1, 16'h007F));
        else if (r < 24)
            return 16'($urandom_range(16'h0080, 16'h07FF));
        else
            return 16'($urandom_range(16'h0800, 16'hFFFF));
    endfunction

    // Builds a payload of the given encoding with random content.
    task automatic make_text(input logic [7:0] enc, input int units);
        logic        be;
        logic [15:0] u;
        int          mark;
        text_q.delete();
        text_q.push_back(enc);
        if (enc == t2u_pkg::ENC_LATIN1 || enc == t2u_pkg::ENC_UTF8)
        begin
            for (int i = 0; i < units; i++)
                text_q.push_back(($urandom_range(0, 19) == 0) ? 8'h00
                                                                : 8'($urandom_range(1, 255)));
        end
        else
        begin
            be = (enc == t2u_pkg::ENC_UTF16BE);
            if (enc == t2u_pkg::ENC_UTF16)
            begin
                mark = $urandom_range(0, 2);
                if (mark == 1)
                begin
                    text_q.push_back(t2u_pkg::MARK_FE);
                    text_q.push_back(t2u_pkg::MARK_FF);
                    be = 1'b1;
                end
                else if (mark == 2)
                begin
                    text_q.push_back(t2u_pkg::MARK_FF);
                    text_q.push_back(t2u_pkg::MARK_FE);
                end
            end
            for (int i = 0; i < units; i++)
            begin
                u = pick_unit();
                text_q.push_back(be ? u[15:8] : u[7:0]);
                text_q.push_back(be ? u[7:0] : u[15:8]);
            end
            // Now and then leave a dangling half unit at the end.
            if ($urandom_range(0, 5) == 0)
                text_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off.
    initial
    begin
        int   left;
        int   r;
        logic hold_done;
        left      = 0;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_done)
            begin
                hold_done = 1'b1;
                left      = 120;
            end
            if (left > 0)
            begin
                result_stall <= 1'b1;
                left--;
            end
            else if (quiet_run)
            begin
                result_stall <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    result_stall <= 1'b0;
                end
                else
                begin
                    result_stall <= 1'b1;
                    left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((payload_valid && !payload_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int r;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty text: encoding byte alone.
        text_q = '{t2u_pkg::ENC_LATIN1};
        send_payload();
        // Pass-through, a zero stop, and a byte after the stop.
        text_q = '{t2u_pkg::ENC_UTF8, 8'h41, 8'hFF, 8'h00, 8'h55};
        send_payload();
        // Big-endian mark, three- and two-byte forms, then a zero unit.
        text_q = '{t2u_pkg::ENC_UTF16, t2u_pkg::MARK_FE, t2u_pkg::MARK_FF,
                   8'h08, 8'h00, 8'h07, 8'hFF, 8'h00, 8'h00};
        send_payload();
        // Little-endian mark, one-byte form, odd trailing byte.
        text_q = '{t2u_pkg::ENC_UTF16, t2u_pkg::MARK_FF, t2u_pkg::MARK_FE,
                   8'h7F, 8'h00, 8'h80};
        send_payload();
        // Big-endian without a mark: largest unit and the smallest two-byte one.
        text_q = '{t2u_pkg::ENC_UTF16BE, 8'hFF, 8'hFF, 8'h00, 8'h80};
        send_payload();
        // An unknown encoding reads little-endian.
        text_q = '{8'hFF, 8'h01, 8'h00};
        send_payload();

        // Keep feeding while the receiver holds off so the block backs up.
        quiet_run    = 1'b1;
        hold_off_req = 1'b1;
        make_text(t2u_pkg::ENC_UTF16BE, 24);
        send_payload();

        while (bytes_sent < 180)
        begin
            quiet_run = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 7) == 0)
            begin
                text_q.delete();
                repeat ($urandom_range(1, 10))
                    text_q.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                r = $urandom_range(0, 9);
                case (r)
                    0:       make_text(t2u_pkg::ENC_LATIN1, $urandom_range(0, 8));
                    1:       make_text(t2u_pkg::ENC_UTF8, $urandom_range(0, 8));
                    2, 3, 4: make_text(t2u_pkg::ENC_UTF16, $urandom_range(0, 6));
                    5, 6, 7: make_text(t2u_pkg::ENC_UTF16BE, $urandom_range(0, 6));
                    default: make_text(8'($urandom_range(4, 255)), $urandom_range(0, 6));
                endcase
            end
            send_payload();
        end
        quiet_run = 1'b0;

        payload_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
design/t2u_pkg.sv
design/t2u_decode.sv
design/t2u_emit.sv
design/tag_text_to_utf8.sv
design/t2u_checker.sv
bench/utf8_stream_check.sv
bench/tb.sv
